// ===== rtl/imu_frame_deframer_sum16_core_assert.svh =====
// Assertion macros for the sum16 deframer core.
// Clocked on clk, disabled while arst_n is low; used by the assembler and output queue.
`ifndef IMU_FRAME_DEFRAMER_SUM16_CORE_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_SUM16_CORE_ASSERT_SVH

// property checked at every edge out of reset
`define IFDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication from one edge to the next
`define IFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ifds_pkg.sv =====
// Shared constants and types for the sum16 deframer.
// No dependencies; imported by every module of the block.
package ifds_pkg;

	localparam int FRAME_BYTES   = 79;
	localparam int NEGATED_WORDS = 9;
	localparam int POS_W         = 7;
	localparam int IDX_W         = 5;
	localparam int WORD_W        = 32;

	typedef enum logic {
		KIND_WORD   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              item_kind;
		logic [IDX_W-1:0]   word_index;
		logic [WORD_W-1:0]  word_value;
		logic               checksum_ok;
		logic               frame_last;
	} res_t;

endpackage

// ===== rtl/ifds_assembler.sv =====
// Input register, frame position/sum/word state and result formation.
// Depends on ifds_pkg and the assertion macro header.
`include "imu_frame_deframer_sum16_core_assert.svh"

module ifds_assembler
	import ifds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        space,
	output logic        push,
	output res_t        res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [POS_W-1:0]  pos_q;
	logic [15:0]       sum_q;
	logic [23:0]       partial_q;
	logic [7:0]        chi_q;

	logic              is_last;
	logic              is_chi;
	logic              word_end;
	logic [IDX_W-1:0]  idx;
	logic              negate;
	logic [WORD_W-1:0] word;
	logic              has_res;
	logic              adv;
	logic              take;

	always_comb begin
		is_last  = pos_q >= POS_W'(FRAME_BYTES - 1);
		is_chi   = pos_q == POS_W'(FRAME_BYTES - 2);
		word_end = (pos_q != '0) && (pos_q[1:0] == 2'b00);
		idx      = IDX_W'(pos_q[POS_W-1:2]) - IDX_W'(1);
		negate   = idx < IDX_W'(NEGATED_WORDS);
		word     = {partial_q, byte_s1};
		has_res  = is_last || (!is_chi && word_end);

		res = '0;
		if (is_last) begin
			res.item_kind   = KIND_STATUS;
			res.checksum_ok = sum_q == {chi_q, byte_s1};
			res.frame_last  = 1'b1;
		end else begin
			res.item_kind  = KIND_WORD;
			res.word_index = idx;
			res.word_value = {word[WORD_W-1] ^ negate, word[WORD_W-2:0]};
		end
	end

	assign adv      = !valid_s1 || !has_res || space;
	assign take     = valid_s1 && adv;
	assign push     = take && has_res;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			partial_q <= '0;
			chi_q     <= '0;
		end else if (take) begin
			if (is_last) begin
				pos_q     <= '0;
				sum_q     <= '0;
				partial_q <= '0;
				chi_q     <= '0;
			end else if (is_chi) begin
				chi_q <= byte_s1;
				pos_q <= pos_q + POS_W'(1);
			end else begin
				sum_q <= sum_q + 16'(byte_s1);
				pos_q <= pos_q + POS_W'(1);
				if (pos_q != '0) begin
					partial_q <= word_end ? 24'h0 : word[23:0];
				end
			end
		end
	end

	`IFDS_ASSERT(a_pos_range, pos_q < POS_W'(FRAME_BYTES), "byte position past frame end")
	`IFDS_ASSERT(a_push_space, push |-> space, "result pushed into full queue")
	`IFDS_ASSERT_NEXT(a_status_wraps, push && res.item_kind == KIND_STATUS,
		pos_q == '0 && sum_q == '0, "frame state not cleared after status")

endmodule

// ===== rtl/ifds_out_queue.sv =====
// Two-entry result queue that decouples the output stall from the input side.
// Depends on ifds_pkg and the assertion macro header.
`include "imu_frame_deframer_sum16_core_assert.svh"

module ifds_out_queue
	import ifds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  res_t        res,
	output logic        space,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        head
);

	res_t        ent_q [2];
	logic        rd_q;
	logic        wr_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign out_valid = cnt_q != 2'd0;
	assign space     = cnt_q != 2'd2;
	assign pop       = out_valid && !out_stall;
	assign head      = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= res;
		end
	end

	`IFDS_ASSERT(a_cnt_max, cnt_q != 2'd3, "queue count out of range")
	`IFDS_ASSERT(a_ptr_cnt, (cnt_q == 2'd1) == (rd_q != wr_q), "queue pointers disagree with count")
	`IFDS_ASSERT_NEXT(a_fill, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "push not counted")

endmodule

// ===== rtl/imu_frame_deframer_sum16_core.sv =====
// Top level of the sum16 fixed-length frame deframer.
// Depends on ifds_pkg, ifds_assembler and ifds_out_queue.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+----
//  in      | in_valid, in_stall, data_byte                    | in
//  out     | out_valid, out_stall, item_kind, word_index,     | out
//          | word_value, checksum_ok, frame_last              |
//
// One byte per cycle unless in_stall is raised; a result passes through the input register,
// then the result queue, before it is presented.
// Reset clears position, sum, partial word and queue; no clearing pass.
// A two-entry queue absorbs output stalls; input stalls only once it is full
// and the byte in the input register would produce a result.
module imu_frame_deframer_sum16_core
	import ifds_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                item_kind,
	output logic [IDX_W-1:0]    word_index,
	output logic [WORD_W-1:0]   word_value,
	output logic                checksum_ok,
	output logic                frame_last
);

	logic space;
	logic push;
	res_t res;
	res_t head;

	ifds_assembler u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.space     (space),
		.push      (push),
		.res       (res)
	);

	ifds_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign item_kind   = logic'(head.item_kind);
	assign word_index  = head.word_index;
	assign word_value  = head.word_value;
	assign checksum_ok = head.checksum_ok;
	assign frame_last  = head.frame_last;

endmodule

// ===== dv/tb_imu_frame_deframer_sum16_core.sv =====
// Testbench for imu_frame_deframer_sum16_core: drives whole frames and checks every word and status.
// A local deframer predicts each result; a directed frame table runs first, then random frames.
// Depends on ifds_pkg and the core RTL only.
module tb_imu_frame_deframer_sum16_core;
	import ifds_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_FRAMES    = 5;
	localparam int STATUS_PREDICTED = -1;

	localparam int FILL_ZERO    = 0;
	localparam int FILL_ONES    = 1;
	localparam int FILL_EXTREME = 2;
	localparam int FILL_RANDOM  = 3;
	localparam int FILL_SPARSE  = 4;

	localparam int CK_GOOD     = 0;
	localparam int CK_BAD_LOW  = 1;
	localparam int CK_BAD_HIGH = 2;
	localparam int CK_RANDOM   = 3;

	typedef struct {
		int fill;
		int ck;
		int exp_ok;
	} frame_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_stall;
	logic               item_kind;
	logic [IDX_W-1:0]   word_index;
	logic [WORD_W-1:0]  word_value;
	logic               checksum_ok;
	logic               frame_last;

	// predictor state
	logic [POS_W-1:0]   frame_pos;
	logic [15:0]        byte_sum;
	logic [23:0]        word_bytes;
	logic [7:0]         csum_hi;
	int                 frames_done;
	int                 typed_status[int];
	res_t               pending_results[$];
	res_t               oldest;

	int                 errors;
	int                 cycles;
	int                 idle_rate;

	frame_row_t directed_frames[4] = '{
		'{FILL_ZERO,    CK_GOOD,    1},
		'{FILL_ONES,    CK_GOOD,    1},
		'{FILL_EXTREME, CK_BAD_LOW, 0},
		'{FILL_SPARSE,  CK_GOOD,    STATUS_PREDICTED}
	};

	imu_frame_deframer_sum16_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.item_kind   (item_kind),
		.word_index  (word_index),
		.word_value  (word_value),
		.checksum_ok (checksum_ok),
		.frame_last  (frame_last)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic deframe_byte(input logic [7:0] b);
		res_t        r;
		logic [31:0] w;
		int          idx;
		r = '0;
		if (frame_pos >= POS_W'(FRAME_BYTES - 1)) begin
			r.item_kind   = KIND_STATUS;
			r.checksum_ok = (byte_sum == {csum_hi, b});
			if (typed_status.exists(frames_done))
				r.checksum_ok = typed_status[frames_done][0];
			r.frame_last  = 1'b1;
			pending_results.push_back(r);
			frame_pos   = '0;
			byte_sum    = '0;
			word_bytes  = '0;
			csum_hi     = '0;
			frames_done++;
		end else if (frame_pos == POS_W'(FRAME_BYTES - 2)) begin
			csum_hi   = b;
			frame_pos = frame_pos + POS_W'(1);
		end else begin
			byte_sum = byte_sum + 16'(b);
			if (frame_pos != '0) begin
				w = {word_bytes, b};
				if (frame_pos[1:0] == 2'b00) begin
					idx = int'(frame_pos) / 4 - 1;
					if (idx < NEGATED_WORDS)
						w[31] = ~w[31];
					r.item_kind  = KIND_WORD;
					r.word_index = IDX_W'(idx);
					r.word_value = w;
					pending_results.push_back(r);
					word_bytes = '0;
				end else begin
					word_bytes = w[23:0];
				end
			end
			frame_pos = frame_pos + POS_W'(1);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				if (in_valid && !in_stall)
					deframe_byte(data_byte);
				if (out_valid && !out_stall) begin
					if (pending_results.size() == 0) begin
						$error("result with nothing pending: kind %0d index %0d value %0h",
							item_kind, word_index, word_value);
						errors++;
					end else begin
						oldest = pending_results.pop_front();
						check_field("item_kind", 32'(oldest.item_kind), 32'(item_kind));
						check_field("word_index", 32'(oldest.word_index), 32'(word_index));
						check_field("word_value", oldest.word_value, word_value);
						check_field("checksum_ok", 32'(oldest.checksum_ok), 32'(checksum_ok));
						check_field("frame_last", 32'(oldest.frame_last), 32'(frame_last));
					end
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [7:0] fill_byte(input int fill, input int p);
		int k;
		int j;
		k = (p - 1) / 4;
		j = (p - 1) % 4;
		case (fill)
			FILL_ZERO:    return 8'h00;
			FILL_ONES:    return 8'hff;
			FILL_EXTREME: begin
				if (p == 0)
					return 8'hff;
				case (k % 4)
					0:       return 8'h00;
					1:       return 8'hff;
					2:       return (j == 0) ? 8'h7f : 8'hff;
					default: return (j == 0) ? 8'h80 : 8'h00;
				endcase
			end
			FILL_SPARSE: begin
				case ($urandom_range(0, 4))
					0:       return 8'h00;
					1:       return 8'hff;
					2:       return 8'h80;
					3:       return 8'h7f;
					default: return 8'($urandom_range(0, 255));
				endcase
			end
			default:      return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input int fill, input int ck);
		logic [7:0]  fb[FRAME_BYTES];
		logic [15:0] sum;
		logic [15:0] ck_word;
		sum = '0;
		for (int p = 0; p < FRAME_BYTES - 2; p++) begin
			fb[p] = fill_byte(fill, p);
			sum   = sum + 16'(fb[p]);
		end
		ck_word = sum;
		case (ck)
			CK_BAD_LOW:  ck_word[7:0]  = sum[7:0] ^ 8'($urandom_range(1, 255));
			CK_BAD_HIGH: ck_word[15:8] = sum[15:8] ^ 8'($urandom_range(1, 255));
			CK_RANDOM:   ck_word       = 16'($urandom_range(0, 65535));
			default:     ck_word       = sum;
		endcase
		fb[FRAME_BYTES-2] = ck_word[15:8];
		fb[FRAME_BYTES-1] = ck_word[7:0];
		for (int p = 0; p < FRAME_BYTES; p++)
			send_byte(fb[p]);
	endtask

	initial begin
		int sel;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= 8'h00;
		frame_pos   = '0;
		byte_sum    = '0;
		word_bytes  = '0;
		csum_hi     = '0;
		frames_done = 0;
		errors      = 0;
		cycles      = 0;
		idle_rate   = 20;
		foreach (directed_frames[i])
			if (directed_frames[i].exp_ok != STATUS_PREDICTED)
				typed_status[i] = directed_frames[i].exp_ok;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_frames[i])
			send_frame(directed_frames[i].fill, directed_frames[i].ck);

		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			case ($urandom_range(0, 2))
				0:       idle_rate = 0;
				1:       idle_rate = 15;
				default: idle_rate = 40;
			endcase
			if (f == RANDOM_FRAMES - 1)
				idle_rate = 0;
			sel = $urandom_range(0, 9);
			send_frame(($urandom_range(0, 1) == 0) ? FILL_RANDOM : FILL_SPARSE,
				(sel < 6) ? CK_GOOD : (sel < 8) ? CK_BAD_LOW : (sel < 9) ? CK_BAD_HIGH : CK_RANDOM);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ifds_pkg.sv
rtl/ifds_assembler.sv
rtl/ifds_out_queue.sv
rtl/imu_frame_deframer_sum16_core.sv
dv/tb_imu_frame_deframer_sum16_core.sv
